[rtl/core/tdpt_pkg.sv]
`default_nettype none

package tdpt_pkg;

    // microprogram counter width and entry points
    localparam int unsigned UPC_W = 4;

    localparam logic [UPC_W-1:0] UPC_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_LOOP   = 4'd4;
    localparam logic [UPC_W-1:0] UPC_DIV    = 4'd5;
    localparam logic [UPC_W-1:0] UPC_FAIL   = 4'd7;
    localparam logic [UPC_W-1:0] UPC_PASS   = 4'd8;
    localparam logic [UPC_W-1:0] UPC_EMIT   = 4'd9;

    // jump condition: jump to target when true, else fall through to pc+1
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_REQ,
        C_LE1,
        C_EQ2,
        C_EVEN,
        C_SQ_GT,
        C_DIV_MORE,
        C_REM_NZ,
        C_OUT_BUSY
    } t_cond;

    // datapath action of one step
    typedef enum logic [2:0] {
        A_NONE,
        A_LOAD,
        A_DIV_INIT,
        A_DIV_STEP,
        A_NEXT_D,
        A_SET0,
        A_SET1,
        A_EMIT
    } t_act;

    typedef struct packed {
        t_cond            cond;
        t_act             act;
        logic [UPC_W-1:0] target;
    } t_uword;

    // remainder unit control
    typedef struct packed {
        logic init;
        logic step;
    } t_rem_ctrl;

    // control store
    function automatic t_uword uc_rom(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{cond: C_ALWAYS, act: A_NONE, target: UPC_IDLE};
        unique case (pc)
            4'd0:    w = '{cond: C_NO_REQ,   act: A_LOAD,     target: UPC_IDLE};
            4'd1:    w = '{cond: C_LE1,      act: A_NONE,     target: UPC_FAIL};
            4'd2:    w = '{cond: C_EQ2,      act: A_NONE,     target: UPC_PASS};
            4'd3:    w = '{cond: C_EVEN,     act: A_NONE,     target: UPC_FAIL};
            4'd4:    w = '{cond: C_SQ_GT,    act: A_DIV_INIT, target: UPC_PASS};
            4'd5:    w = '{cond: C_DIV_MORE, act: A_DIV_STEP, target: UPC_DIV};
            4'd6:    w = '{cond: C_REM_NZ,   act: A_NEXT_D,   target: UPC_LOOP};
            4'd7:    w = '{cond: C_ALWAYS,   act: A_SET0,     target: UPC_EMIT};
            4'd8:    w = '{cond: C_NEVER,    act: A_SET1,     target: UPC_IDLE};
            4'd9:    w = '{cond: C_OUT_BUSY, act: A_EMIT,     target: UPC_EMIT};
            4'd10:   w = '{cond: C_ALWAYS,   act: A_NONE,     target: UPC_IDLE};
            default: w = '{cond: C_ALWAYS,   act: A_NONE,     target: UPC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/core/tdpt_rem_unit.sv]
`default_nettype none

// Bit-serial restoring remainder: one dividend bit per cycle while step is asserted, MSB first.
module tdpt_rem_unit #(
    parameter int unsigned W = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tdpt_pkg::t_rem_ctrl  i_ctrl,
    input  wire  [W-1:0]         i_dividend,
    input  wire  [W-1:0]         i_divisor,
    output logic [W-1:0]         o_rem,
    output logic                 o_more
);

    localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;
    localparam logic [CW-1:0] LAST = CW'(W - 1);

    logic [W-1:0]  r_rem,   n_rem;
    logic [W-1:0]  r_shift, n_shift;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [W:0]    trial;
    logic [W:0]    diff;

    always_comb begin
        trial   = {r_rem, r_shift[W-1]};
        diff    = trial - {1'b0, i_divisor};
        n_rem   = r_rem;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        if (i_ctrl.init) begin
            n_rem   = '0;
            n_shift = i_dividend;
            n_cnt   = '0;
        end else if (i_ctrl.step) begin
            // remainder stays below divisor, so W bits suffice after restore
            n_rem   = diff[W] ? trial[W-1:0] : diff[W-1:0];
            n_shift = {r_shift[W-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_rem   <= n_rem;
        r_shift <= n_shift;
    end

    assign o_rem  = r_rem;
    assign o_more = (r_cnt != LAST);

endmodule

`default_nettype wire

[rtl/core/trial_division_prime_test.sv]
`default_nettype none

// Trial-division primality test.
// Slave channel (i_s_*): one request carries the value to test in tdata.
// Master channel (o_m_*): one result per request, bit 0 of tdata = prime flag.
// Control is a microprogram in a small control store; each step drives
// the datapath and may jump on a condition.
// Values 0 and 1 give 0, 2 gives 1, other even values give 0. Odd values
// try divisors d = 3, 5, 7, ... while d*d <= value; each candidate is
// checked by the bit-serial remainder unit (one dividend bit per cycle).
// d*d is kept incrementally. Up to ~2^(VALUE_WIDTH/2 - 1) candidates are
// tried for a large prime.
// One request is worked on at a time; the next request is taken once the
// sequencer has left its emit step and returned to idle, even if the
// previous result is not yet taken.
// Receiver stall: the result holds in the output register; the sequencer
// waits at its emit step only if a second result is ready before then.
// Reset clears the sequencer and the output valid; no clearing pass.
module trial_division_prime_test #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_tvalid,
    output logic                      o_s_tready,
    input  wire  [((VALUE_WIDTH+7)/8)*8-1:0] i_s_tdata,  // [VALUE_WIDTH-1:0] value
    output logic                      o_m_tvalid,
    input  wire                       i_m_tready,
    output logic [7:0]                o_m_tdata          // [0] prime flag
);

    localparam int unsigned W  = VALUE_WIDTH;
    localparam int unsigned SW = VALUE_WIDTH + 2;

    tdpt_pkg::t_uword uw;

    logic [tdpt_pkg::UPC_W-1:0] r_pc, n_pc;
    logic [W-1:0]  r_n, n_n;      // value under test
    logic [W-1:0]  r_d, n_d;      // candidate divisor
    logic [SW-1:0] r_sq, n_sq;    // r_d * r_d
    logic          r_flag, n_flag;
    logic          r_out_valid, n_out_valid;
    logic          r_out_prime, n_out_prime;

    tdpt_pkg::t_rem_ctrl rem_ctrl;
    logic [W-1:0]        rem;
    logic                rem_more;
    logic                cond_hit;
    logic                out_busy;

    tdpt_rem_unit #(
        .W (W)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (rem_ctrl),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_rem      (rem),
        .o_more     (rem_more)
    );

    assign uw       = tdpt_pkg::uc_rom(r_pc);
    assign out_busy = r_out_valid && !i_m_tready;

    always_comb begin
        unique case (uw.cond)
            tdpt_pkg::C_NEVER:    cond_hit = 1'b0;
            tdpt_pkg::C_ALWAYS:   cond_hit = 1'b1;
            tdpt_pkg::C_NO_REQ:   cond_hit = !i_s_tvalid;
            tdpt_pkg::C_LE1:      cond_hit = (r_n[W-1:1] == '0);
            tdpt_pkg::C_EQ2:      cond_hit = (r_n == W'(2));
            tdpt_pkg::C_EVEN:     cond_hit = !r_n[0];
            tdpt_pkg::C_SQ_GT:    cond_hit = (r_sq > {2'b00, r_n});
            tdpt_pkg::C_DIV_MORE: cond_hit = rem_more;
            tdpt_pkg::C_REM_NZ:   cond_hit = (rem != '0);
            tdpt_pkg::C_OUT_BUSY: cond_hit = out_busy;
            default:              cond_hit = 1'b1;
        endcase
    end

    always_comb begin
        n_pc        = cond_hit ? uw.target : r_pc + 1'b1;
        n_n         = r_n;
        n_d         = r_d;
        n_sq        = r_sq;
        n_flag      = r_flag;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_prime = r_out_prime;
        rem_ctrl    = '{init: 1'b0, step: 1'b0};
        o_s_tready  = 1'b0;
        unique case (uw.act)
            tdpt_pkg::A_NONE: begin
            end
            tdpt_pkg::A_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_n  = i_s_tdata[W-1:0];
                    n_d  = W'(3);
                    n_sq = SW'(9);
                end
            end
            tdpt_pkg::A_DIV_INIT: rem_ctrl.init = 1'b1;
            tdpt_pkg::A_DIV_STEP: rem_ctrl.step = 1'b1;
            tdpt_pkg::A_NEXT_D: begin
                // (d+2)^2 = d^2 + 4d + 4
                n_d  = r_d + W'(2);
                n_sq = r_sq + {r_d, 2'b00} + SW'(4);
            end
            tdpt_pkg::A_SET0: n_flag = 1'b0;
            tdpt_pkg::A_SET1: n_flag = 1'b1;
            tdpt_pkg::A_EMIT: begin
                if (!out_busy) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_flag;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= tdpt_pkg::UPC_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
        end
        r_n         <= n_n;
        r_d         <= n_d;
        r_sq        <= n_sq;
        r_flag      <= n_flag;
        r_out_prime <= n_out_prime;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_out_prime};

endmodule

`default_nettype wire
